// ===== rtl/qvr_pkg.sv =====
// ----------------------------------------------------------------------------
// qvr_pkg - shared constants for the quaternion vector rotation block
// Default component widths and the pipeline depth seen at the ports.
// ----------------------------------------------------------------------------
package qvr_pkg;

    // quaternion components: signed Q1.(QUAT_WIDTH-2)
    localparam int QVR_QUAT_WIDTH = 16;
    // vector components: signed, same format in and out
    localparam int QVR_VEC_WIDTH  = 32;
    // cycles from an accepted request to its result, no stalls
    localparam int QVR_LATENCY    = 5;

endpackage

// ===== rtl/quaternion_vector_rotation.sv =====
// ----------------------------------------------------------------------------
// quaternion_vector_rotation - rotate a 3-vector by q * (0,v) * conj(q)
// Five-stage pipeline: two multiply/sum rounds, round to nearest, saturate.
// ----------------------------------------------------------------------------
// Usage
//   Input channel: i_valid / o_stall carries one request: a quaternion
//   (i_quat_w..z, signed Q1.14) and a vector (i_vec_x..z, signed Q16.16).
//   Output channel: o_valid / i_stall carries the rotated vector
//   (o_rot_x..z) and o_saturated, set when any component was clipped.
//   The quaternion is not normalized; the result scales with |q|^2.
//   When the receiver does not stall, the block takes one request per
//   cycle; each request passes through the stage registers in order, and
//   o_valid rises when it reaches the output register.
//   The stages are: products q*v, sums/round to p, products p*conj(q),
//   sums/round, saturate into the output register. Each stage holds a
//   valid bit and advances when it is empty or the next stage moves, so
//   bubbles collapse under a stall and o_stall rises only when all five
//   stages are full and i_stall is high.
//   Reset (synchronous, active low) clears all valid bits; nothing else
//   is kept from one request to the next.
// ----------------------------------------------------------------------------
module quaternion_vector_rotation
    import qvr_pkg::*;
#(
    parameter int QUAT_WIDTH = QVR_QUAT_WIDTH,
    parameter int VEC_WIDTH  = QVR_VEC_WIDTH
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic signed [QUAT_WIDTH-1:0] i_quat_w,
    input  logic signed [QUAT_WIDTH-1:0] i_quat_x,
    input  logic signed [QUAT_WIDTH-1:0] i_quat_y,
    input  logic signed [QUAT_WIDTH-1:0] i_quat_z,
    input  logic signed [VEC_WIDTH-1:0]  i_vec_x,
    input  logic signed [VEC_WIDTH-1:0]  i_vec_y,
    input  logic signed [VEC_WIDTH-1:0]  i_vec_z,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic signed [VEC_WIDTH-1:0]  o_rot_x,
    output logic signed [VEC_WIDTH-1:0]  o_rot_y,
    output logic signed [VEC_WIDTH-1:0]  o_rot_z,
    output logic                         o_saturated
);

    localparam int QW   = QUAT_WIDTH;
    localparam int VW   = VEC_WIDTH;
    localparam int FB   = QW - 2;          // fraction bits of q
    localparam int M1W  = QW + VW;         // q * v product
    localparam int S1W  = M1W + 2;         // sum of three products + half
    localparam int PW   = VW + 3;          // p components, never clipped
    localparam int M2W  = PW + QW;         // p * q product
    localparam int S2W  = M2W + 2;         // sum of four products + half
    localparam int RW   = S2W - FB;        // rounded result before clipping

    localparam logic signed [S1W-1:0] HALF1 = S1W'(1) <<< (FB - 1);
    localparam logic signed [S2W-1:0] HALF2 = S2W'(1) <<< (FB - 1);
    localparam logic signed [VW-1:0]  VMAX  = {1'b0, {(VW-1){1'b1}}};
    localparam logic signed [VW-1:0]  VMIN  = {1'b1, {(VW-1){1'b0}}};

    // stage valid bits and advance enables
    logic r_v1, r_v2, r_v3, r_v4, r_v5;
    logic n_v1, n_v2, n_v3, n_v4, n_v5;
    logic rdy1, rdy2, rdy3, rdy4, rdy5;

    // stage 1: q * v products
    logic signed [M1W-1:0] r_m1 [12];
    logic signed [M1W-1:0] n_m1 [12];
    logic signed [QW-1:0]  r_q1 [4];

    // stage 2: p = q * (0,v), rounded
    logic signed [PW-1:0]  r_p [4];
    logic signed [PW-1:0]  n_p [4];
    logic signed [S1W-1:0] sum1 [4];
    logic signed [QW-1:0]  r_q2 [4];

    // stage 3: p * conj(q) products
    logic signed [M2W-1:0] r_m2 [12];
    logic signed [M2W-1:0] n_m2 [12];

    // stage 4: rounded vector part
    logic signed [RW-1:0]  r_r [3];
    logic signed [RW-1:0]  n_r [3];
    logic signed [S2W-1:0] sum2 [3];

    // stage 5: saturated output
    logic signed [VW-1:0]  r_o [3];
    logic signed [VW-1:0]  n_o [3];
    logic [2:0]            clip;
    logic                  r_sat;

    // advance chain: a stage moves when empty or when its successor moves
    always_comb begin
        rdy5 = !r_v5 || !i_stall;
        rdy4 = !r_v4 || rdy5;
        rdy3 = !r_v3 || rdy4;
        rdy2 = !r_v2 || rdy3;
        rdy1 = !r_v1 || rdy2;
        n_v1 = i_valid;
        n_v2 = r_v1;
        n_v3 = r_v2;
        n_v4 = r_v3;
        n_v5 = r_v4;
    end

    assign o_stall = !rdy1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else begin
            if (rdy1) r_v1 <= n_v1;
            if (rdy2) r_v2 <= n_v2;
            if (rdy3) r_v3 <= n_v3;
            if (rdy4) r_v4 <= n_v4;
            if (rdy5) r_v5 <= n_v5;
        end
    end

    // stage 1 products, grouped by p component
    always_comb begin
        n_m1[0]  = i_quat_x * i_vec_x;   // pw
        n_m1[1]  = i_quat_y * i_vec_y;
        n_m1[2]  = i_quat_z * i_vec_z;
        n_m1[3]  = i_quat_w * i_vec_x;   // px
        n_m1[4]  = i_quat_y * i_vec_z;
        n_m1[5]  = i_quat_z * i_vec_y;
        n_m1[6]  = i_quat_w * i_vec_y;   // py
        n_m1[7]  = i_quat_x * i_vec_z;
        n_m1[8]  = i_quat_z * i_vec_x;
        n_m1[9]  = i_quat_w * i_vec_z;   // pz
        n_m1[10] = i_quat_x * i_vec_y;
        n_m1[11] = i_quat_y * i_vec_x;
    end

    always_ff @(posedge i_clk) begin
        if (rdy1) begin
            r_m1    <= n_m1;
            r_q1[0] <= i_quat_w;
            r_q1[1] <= i_quat_x;
            r_q1[2] <= i_quat_y;
            r_q1[3] <= i_quat_z;
        end
    end

    // stage 2: signed sums, round half up, drop fraction bits
    always_comb begin
        sum1[0] = HALF1 - S1W'(r_m1[0]) - S1W'(r_m1[1]) - S1W'(r_m1[2]);
        sum1[1] = HALF1 + S1W'(r_m1[3]) + S1W'(r_m1[4]) - S1W'(r_m1[5]);
        sum1[2] = HALF1 + S1W'(r_m1[6]) - S1W'(r_m1[7]) + S1W'(r_m1[8]);
        sum1[3] = HALF1 + S1W'(r_m1[9]) + S1W'(r_m1[10]) - S1W'(r_m1[11]);
        for (int k = 0; k < 4; k++) begin
            n_p[k] = PW'(sum1[k] >>> FB);
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy2) begin
            r_p  <= n_p;
            r_q2 <= r_q1;
        end
    end

    // stage 3: products of p with the conjugate (q index: w=0 x=1 y=2 z=3)
    always_comb begin
        n_m2[0]  = r_p[0] * r_q2[1];   // rx
        n_m2[1]  = r_p[1] * r_q2[0];
        n_m2[2]  = r_p[2] * r_q2[3];
        n_m2[3]  = r_p[3] * r_q2[2];
        n_m2[4]  = r_p[0] * r_q2[2];   // ry
        n_m2[5]  = r_p[1] * r_q2[3];
        n_m2[6]  = r_p[2] * r_q2[0];
        n_m2[7]  = r_p[3] * r_q2[1];
        n_m2[8]  = r_p[0] * r_q2[3];   // rz
        n_m2[9]  = r_p[1] * r_q2[2];
        n_m2[10] = r_p[2] * r_q2[1];
        n_m2[11] = r_p[3] * r_q2[0];
    end

    always_ff @(posedge i_clk) begin
        if (rdy3) begin
            r_m2 <= n_m2;
        end
    end

    // stage 4: sums with conjugate signs, round half up
    always_comb begin
        sum2[0] = HALF2 - S2W'(r_m2[0]) + S2W'(r_m2[1])
                        - S2W'(r_m2[2]) + S2W'(r_m2[3]);
        sum2[1] = HALF2 - S2W'(r_m2[4]) + S2W'(r_m2[5])
                        + S2W'(r_m2[6]) - S2W'(r_m2[7]);
        sum2[2] = HALF2 - S2W'(r_m2[8]) - S2W'(r_m2[9])
                        + S2W'(r_m2[10]) + S2W'(r_m2[11]);
        for (int k = 0; k < 3; k++) begin
            n_r[k] = RW'(sum2[k] >>> FB);
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy4) begin
            r_r <= n_r;
        end
    end

    // stage 5: clip to the vector range when the upper bits are not a sign run
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            clip[k] = !((&r_r[k][RW-1:VW-1]) || !(|r_r[k][RW-1:VW-1]));
            if (!clip[k]) begin
                n_o[k] = r_r[k][VW-1:0];
            end else if (r_r[k][RW-1]) begin
                n_o[k] = VMIN;
            end else begin
                n_o[k] = VMAX;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy5) begin
            r_o   <= n_o;
            r_sat <= |clip;
        end
    end

    assign o_valid     = r_v5;
    assign o_rot_x     = r_o[0];
    assign o_rot_y     = r_o[1];
    assign o_rot_z     = r_o[2];
    assign o_saturated = r_sat;

endmodule

// ===== rtl/qvr_checker.sv =====
// ----------------------------------------------------------------------------
// qvr_checker - port-level checks for quaternion_vector_rotation
// Watches the handshakes and the result flags; bound to the top level.
// ----------------------------------------------------------------------------
module qvr_checker
    import qvr_pkg::*;
#(
    parameter int QUAT_WIDTH = QVR_QUAT_WIDTH,
    parameter int VEC_WIDTH  = QVR_VEC_WIDTH
) (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_valid,
    input logic                         o_stall,
    input logic signed [QUAT_WIDTH-1:0] i_quat_w,
    input logic signed [QUAT_WIDTH-1:0] i_quat_x,
    input logic signed [QUAT_WIDTH-1:0] i_quat_y,
    input logic signed [QUAT_WIDTH-1:0] i_quat_z,
    input logic signed [VEC_WIDTH-1:0]  i_vec_x,
    input logic signed [VEC_WIDTH-1:0]  i_vec_y,
    input logic signed [VEC_WIDTH-1:0]  i_vec_z,
    input logic                         o_valid,
    input logic                         i_stall,
    input logic signed [VEC_WIDTH-1:0]  o_rot_x,
    input logic signed [VEC_WIDTH-1:0]  o_rot_y,
    input logic signed [VEC_WIDTH-1:0]  o_rot_z,
    input logic                         o_saturated
);

    localparam logic signed [VEC_WIDTH-1:0] VMAX = {1'b0, {(VEC_WIDTH-1){1'b1}}};
    localparam logic signed [VEC_WIDTH-1:0] VMIN = {1'b1, {(VEC_WIDTH-1){1'b0}}};

    logic x_end, y_end, z_end;
    logic q_known;

    assign x_end   = (o_rot_x == VMAX) || (o_rot_x == VMIN);
    assign y_end   = (o_rot_y == VMAX) || (o_rot_y == VMIN);
    assign z_end   = (o_rot_z == VMAX) || (o_rot_z == VMIN);
    assign q_known = !$isunknown({i_quat_w, i_quat_x, i_quat_y, i_quat_z,
                                  i_vec_x, i_vec_y, i_vec_z});

    // no result shows right after a reset cycle
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

    // a request is held back only when the result register is backed up
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall))
        else $error("input stalled while the output is free");

    // a stalled result holds its value
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_rot_x) && $stable(o_rot_y)
                                  && $stable(o_rot_z) && $stable(o_saturated)))
        else $error("stalled result changed");

    // a clipped result has at least one component at a range end
    a_sat_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_saturated) |-> (x_end || y_end || z_end))
        else $error("saturated flag without a clipped component");

    // an accepted request carries a known payload
    a_req_known: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |-> q_known)
        else $error("request accepted with unknown payload");

endmodule

bind quaternion_vector_rotation qvr_checker #(
    .QUAT_WIDTH (QUAT_WIDTH),
    .VEC_WIDTH  (VEC_WIDTH)
) u_qvr_checker (.*);
